// ===== rtl/gas_pkg.sv =====
`timescale 1ns / 1ps

package gas_pkg;

   // Default configuration of the allocator.
   localparam int DEF_PAGE_SIDE    = 256;
   localparam int DEF_MAX_PAGES    = 64;
   localparam int DEF_SIZE_CLASSES = 4;

   // Row height of the smallest class; each further class doubles it.
   localparam int BASE_ROW  = 16;

   // Largest value an 8-bit glyph dimension can take.
   localparam int GLYPH_MAX = 255;

   localparam int DIM_W     = 8;
   localparam int STATUS_W  = 2;
   localparam int PAGE_NO_W = 6;
   localparam int CLASS_O_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_PLACED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_TALL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_PAGE  = 2'd2;

endpackage

// ===== rtl/gas_class_sel.sv =====
`timescale 1ns / 1ps

// Picks the first size class whose row height is strictly above the glyph height.
module gas_class_sel #(
   parameter int SIZE_CLASSES = gas_pkg::DEF_SIZE_CLASSES,
   parameter int CLS_W        = 2
) (
   input  logic [gas_pkg::DIM_W-1:0] height,
   output logic [CLS_W-1:0]          cls,
   output logic                      too_tall
);
   import gas_pkg::*;

   localparam int ROW_MAX = BASE_ROW << (SIZE_CLASSES - 1);

   // Scanning from the top class down leaves the lowest fitting class in cls.
   always_comb begin
      cls = '0;
      for (int k = SIZE_CLASSES - 1; k >= 0; k--) begin
         if (32'(height) < (BASE_ROW << k)) begin
            cls = CLS_W'(k);
         end
      end
      too_tall = (32'(height) >= ROW_MAX);
   end

endmodule

// ===== rtl/glyph_atlas_shelf_allocator.sv =====
`timescale 1ns / 1ps

// Glyph atlas shelf allocator.
// A request on the req_ channel carries one glyph's width and height. The block chooses
// a size class from the height and places the glyph on that class's current page by
// shelf packing, opening a fresh page from a global counter when needed. Each request
// gives exactly one response on the rsp_ channel: status, page, x, y, class and a flag
// that is set when a page was opened for this glyph.
// An accepted request is held in the placement stage and its response then goes to the
// output register, which drives rsp_valid. One request is taken every cycle while the
// receiver keeps up: the per-class page and cursor state sits in a small memory with a
// registered read, and the entry written by the previous request is forwarded to the next
// one, so requests for the same class may follow each other directly.
// Reset clears the page-present bit of every class and the page counter; no clearing
// pass runs, and the block takes requests as soon as reset is released.
// When the receiver holds rsp_ready low, the response waits in the output register; one
// further request may still be taken and waits in the placement stage, after which
// req_ready drops until the response is taken.
module glyph_atlas_shelf_allocator #(
   parameter int PAGE_SIDE    = gas_pkg::DEF_PAGE_SIDE,
   parameter int MAX_PAGES    = gas_pkg::DEF_MAX_PAGES,
   parameter int SIZE_CLASSES = gas_pkg::DEF_SIZE_CLASSES
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gas_pkg::DIM_W-1:0]         req_glyph_width,
   input  logic [gas_pkg::DIM_W-1:0]         req_glyph_height,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gas_pkg::STATUS_W-1:0]      rsp_status,
   output logic [gas_pkg::PAGE_NO_W-1:0]     rsp_page_number,
   output logic [gas_pkg::DIM_W-1:0]         rsp_pos_x,
   output logic [gas_pkg::DIM_W-1:0]         rsp_pos_y,
   output logic [gas_pkg::CLASS_O_W-1:0]     rsp_size_class,
   output logic                              rsp_opened_page
);
   import gas_pkg::*;

   // Widths that follow from the parameters.
   localparam int CLS_W   = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
   localparam int PG_W    = $clog2(MAX_PAGES);
   localparam int CNT_W   = $clog2(MAX_PAGES + 1);
   localparam int X_MAX   = ((PAGE_SIDE > GLYPH_MAX) ? PAGE_SIDE : GLYPH_MAX) + 1;
   localparam int XW      = $clog2(X_MAX + 1);
   localparam int XS_W    = XW + 1;
   localparam int YW      = $clog2(PAGE_SIDE + 1);
   localparam int ROW_MAX = BASE_ROW << (SIZE_CLASSES - 1);
   localparam int SUM_W   = $clog2(PAGE_SIDE + 2 * ROW_MAX + 3) + 1;

   // One entry of the class-state memory. The page-present bits live in flip-flops
   // beside it, so that reset can clear them at once.
   typedef struct packed {
      logic [PG_W-1:0] page;
      logic [XW-1:0]   cur_x;
      logic [YW-1:0]   cur_y;
   } entry_type;

   // ---------------------------------------------------------------------------------
   // Request side: class selection and memory read.
   // ---------------------------------------------------------------------------------
   logic             req_accept;
   logic [CLS_W-1:0] req_class;
   logic             req_too_tall;

   gas_class_sel #(
      .SIZE_CLASSES (SIZE_CLASSES),
      .CLS_W        (CLS_W)
   ) u_class_sel (
      .height   (req_glyph_height),
      .cls      (req_class),
      .too_tall (req_too_tall)
   );

   entry_type class_mem [SIZE_CLASSES];
   entry_type mem_rd_ff;

   logic             wr_en;
   entry_type        wr_data;

   // Placement stage registers.
   logic             s1_valid_ff, s1_valid_in;
   logic [DIM_W-1:0] s1_width_ff, s1_width_in;
   logic [CLS_W-1:0] s1_class_ff, s1_class_in;
   logic             s1_tall_ff, s1_tall_in;
   logic             s1_advance;

   // Last write to the memory, for forwarding to a request that read stale data.
   logic             fwd_valid_ff, fwd_valid_in;
   logic [CLS_W-1:0] fwd_class_ff, fwd_class_in;
   entry_type        fwd_data_ff, fwd_data_in;

   logic [SIZE_CLASSES-1:0] has_page_ff, has_page_in;
   logic [CNT_W-1:0]        pages_used_ff, pages_used_in;

   // Output register.
   logic                 out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]  out_status_ff, out_status_in;
   logic [PAGE_NO_W-1:0] out_page_ff, out_page_in;
   logic [DIM_W-1:0]     out_x_ff, out_x_in;
   logic [DIM_W-1:0]     out_y_ff, out_y_in;
   logic [CLASS_O_W-1:0] out_class_ff, out_class_in;
   logic                 out_opened_ff, out_opened_in;

   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   // The memory: one write port from the placement stage, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         class_mem[s1_class_ff] <= wr_data;
      end
      if (req_accept) begin
         mem_rd_ff <= class_mem[req_class];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      s1_width_in = req_accept ? req_glyph_width  : s1_width_ff;
      s1_class_in = req_accept ? req_class        : s1_class_ff;
      s1_tall_in  = req_accept ? req_too_tall     : s1_tall_ff;
   end

   // ---------------------------------------------------------------------------------
   // Placement stage: shelf step on the class entry.
   // ---------------------------------------------------------------------------------
   entry_type        cur;
   logic             has;
   logic [SUM_W-1:0] fh;
   logic [XS_W-1:0]  sum_x;
   logic             wrap;
   logic [SUM_W-1:0] y_eff;
   logic [YW-1:0]    y_store;
   logic [XW-1:0]    x_eff;
   logic [XS_W-1:0]  next_x;
   logic             need_new;
   logic             pages_full;

   always_comb begin
      // The most recent write is always at least as new as the memory read.
      cur = (fwd_valid_ff && fwd_class_ff == s1_class_ff) ? fwd_data_ff : mem_rd_ff;
      has = has_page_ff[s1_class_ff];

      fh     = SUM_W'(BASE_ROW) << s1_class_ff;
      sum_x  = XS_W'(cur.cur_x) + XS_W'(s1_width_ff);
      wrap   = has && (sum_x > XS_W'(PAGE_SIDE));
      x_eff  = wrap ? '0 : cur.cur_x;
      next_x = wrap ? XS_W'(s1_width_ff) : sum_x;
      y_eff  = wrap ? (SUM_W'(cur.cur_y) + fh + SUM_W'(1)) : SUM_W'(cur.cur_y);

      // Any row at or beyond the page side forces a new page, so the stored row
      // saturates there rather than growing.
      y_store = (y_eff > SUM_W'(PAGE_SIDE)) ? YW'(PAGE_SIDE) : YW'(y_eff);

      need_new   = !has || ((y_eff + fh + SUM_W'(1)) > SUM_W'(PAGE_SIDE));
      pages_full = (pages_used_ff >= CNT_W'(MAX_PAGES));
   end

   always_comb begin
      wr_en         = 1'b0;
      wr_data       = cur;
      has_page_in   = has_page_ff;
      pages_used_in = pages_used_ff;

      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_page_in   = out_page_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_class_in  = out_class_ff;
      out_opened_in = out_opened_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (s1_advance) begin
         out_valid_in  = 1'b1;
         out_status_in = STATUS_PLACED;
         out_page_in   = '0;
         out_x_in      = '0;
         out_y_in      = '0;
         out_class_in  = CLASS_O_W'(s1_class_ff);
         out_opened_in = 1'b0;

         priority if (s1_tall_ff) begin
            out_status_in = STATUS_TOO_TALL;
            out_class_in  = '0;
         end else if (need_new && pages_full) begin
            // The row wrap made on the current page is kept.
            out_status_in = STATUS_NO_PAGE;
            wr_en         = wrap;
            wr_data.cur_x = '0;
            wr_data.cur_y = y_store;
         end else if (need_new) begin
            wr_en                    = 1'b1;
            wr_data.page             = PG_W'(pages_used_ff);
            wr_data.cur_x            = XW'(s1_width_ff) + XW'(1);
            wr_data.cur_y            = '0;
            has_page_in[s1_class_ff] = 1'b1;
            pages_used_in            = pages_used_ff + CNT_W'(1);
            out_page_in              = PAGE_NO_W'(pages_used_ff);
            out_opened_in            = 1'b1;
         end else begin
            wr_en         = 1'b1;
            wr_data.cur_x = XW'(next_x + XS_W'(1));
            wr_data.cur_y = y_store;
            out_page_in   = PAGE_NO_W'(cur.page);
            out_x_in      = DIM_W'(x_eff);
            out_y_in      = DIM_W'(y_store);
         end
      end

      fwd_valid_in = fwd_valid_ff || wr_en;
      fwd_class_in = wr_en ? s1_class_ff : fwd_class_ff;
      fwd_data_in  = wr_en ? wr_data     : fwd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         has_page_ff   <= '0;
         pages_used_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         has_page_ff   <= has_page_in;
         pages_used_ff <= pages_used_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_width_ff   <= s1_width_in;
      s1_class_ff   <= s1_class_in;
      s1_tall_ff    <= s1_tall_in;
      fwd_class_ff  <= fwd_class_in;
      fwd_data_ff   <= fwd_data_in;
      out_status_ff <= out_status_in;
      out_page_ff   <= out_page_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_class_ff  <= out_class_in;
      out_opened_ff <= out_opened_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_page_number = out_page_ff;
   assign rsp_pos_x       = out_x_ff;
   assign rsp_pos_y       = out_y_ff;
   assign rsp_size_class  = out_class_ff;
   assign rsp_opened_page = out_opened_ff;

   // ---------------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------------
   a_pages_bounded: assert property (@(posedge clock) disable iff (reset)
      pages_used_ff <= CNT_W'(MAX_PAGES))
      else $error("page counter exceeds the number of pages");

   a_open_counts: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && !s1_tall_ff && need_new && !pages_full)
         |=> (pages_used_ff == $past(pages_used_ff) + CNT_W'(1)))
      else $error("opening a page did not advance the page counter");

   a_has_page_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((($past(has_page_ff)) & ~has_page_ff) == '0))
      else $error("a class lost its page");

   a_opened_origin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_opened_page)
         |-> (rsp_status == STATUS_PLACED && rsp_pos_x == '0 && rsp_pos_y == '0))
      else $error("a newly opened page did not place the glyph at the origin");

   a_tall_no_write: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_tall_ff) |-> !wr_en)
      else $error("a too-tall glyph changed the class state");

endmodule

// ===== test/glyph_atlas_shelf_checker.sv =====
`timescale 1ns / 1ps

module glyph_atlas_shelf_checker #(
   parameter int PAGE_SIDE    = gas_pkg::DEF_PAGE_SIDE,
   parameter int MAX_PAGES    = gas_pkg::DEF_MAX_PAGES,
   parameter int SIZE_CLASSES = gas_pkg::DEF_SIZE_CLASSES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [gas_pkg::DIM_W-1:0]     req_glyph_width,
   input  logic [gas_pkg::DIM_W-1:0]     req_glyph_height,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [gas_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [gas_pkg::PAGE_NO_W-1:0] rsp_page_number,
   input  logic [gas_pkg::DIM_W-1:0]     rsp_pos_x,
   input  logic [gas_pkg::DIM_W-1:0]     rsp_pos_y,
   input  logic [gas_pkg::CLASS_O_W-1:0] rsp_size_class,
   input  logic                          rsp_opened_page,
   output int                            fail_count,
   output int                            placements_due,
   output int                            requests_seen,
   output int                            responses_seen,
   output int                            pages_opened,
   output int                            too_tall_seen,
   output int                            no_page_seen
);

   import gas_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [PAGE_NO_W-1:0] page_number;
      logic [DIM_W-1:0]     pos_x;
      logic [DIM_W-1:0]     pos_y;
      logic [CLASS_O_W-1:0] size_class;
      logic                 opened_page;
   } placement_type;

   // Shadow of the allocator: per-class page and shelf cursors, and the page counter.
   bit                   class_open   [SIZE_CLASSES];
   logic [PAGE_NO_W-1:0] class_page_no[SIZE_CLASSES];
   int unsigned          shelf_x      [SIZE_CLASSES];
   int unsigned          shelf_y      [SIZE_CLASSES];
   int unsigned          pages_taken;

   placement_type open_placements[$];

   task automatic report_mismatch(input string what);
      $display("[%0t ns] response %0d mismatch: %s", $time, responses_seen, what);
      fail_count++;
   endtask

   function automatic placement_type place_glyph(input logic [DIM_W-1:0] w,
                                                 input logic [DIM_W-1:0] h);
      placement_type r;
      int            cls;
      int            k;
      int unsigned   row;
      int unsigned   nxt;
      bit            fresh;
      r   = '0;
      cls = -1;
      for (k = 0; k < SIZE_CLASSES; k++)
         if (cls < 0 && h < (BASE_ROW << k))
            cls = k;
      if (cls < 0) begin
         r.status = STATUS_TOO_TALL;
         return r;
      end
      row          = BASE_ROW << cls;
      r.size_class = CLASS_O_W'(cls);
      nxt          = 32'(w);
      fresh        = 1'b1;
      if (class_open[cls]) begin
         nxt = shelf_x[cls] + 32'(w);
         if (nxt > PAGE_SIDE) begin
            // The shelf is full: start the next one down. This stays even if no page follows.
            shelf_x[cls] = 0;
            nxt          = 32'(w);
            shelf_y[cls] = shelf_y[cls] + row + 1;
         end
         fresh = (shelf_y[cls] + row + 1) > PAGE_SIDE;
      end
      if (fresh) begin
         if (pages_taken >= MAX_PAGES) begin
            r.status = STATUS_NO_PAGE;
            return r;
         end
         class_page_no[cls] = PAGE_NO_W'(pages_taken);
         pages_taken        = pages_taken + 1;
         class_open[cls]    = 1'b1;
         shelf_x[cls]       = 0;
         shelf_y[cls]       = 0;
         nxt                = 32'(w);
         r.opened_page      = 1'b1;
      end
      r.status      = STATUS_PLACED;
      r.page_number = class_page_no[cls];
      r.pos_x       = DIM_W'(shelf_x[cls]);
      r.pos_y       = DIM_W'(shelf_y[cls]);
      shelf_x[cls]  = nxt + 1;
      return r;
   endfunction

   // Sampled at the falling edge, where both channels are settled; a handshake seen here
   // completes at the following rising edge. Responses are taken before requests, since a
   // response can never belong to a request accepted at the same edge.
   always @(negedge clock) begin
      placement_type due;
      int            k;
      if (reset) begin
         for (k = 0; k < SIZE_CLASSES; k++) begin
            class_open[k]    = 1'b0;
            class_page_no[k] = '0;
            shelf_x[k]       = 0;
            shelf_y[k]       = 0;
         end
         pages_taken = 0;
         open_placements.delete();
         fail_count     = 0;
         requests_seen  = 0;
         responses_seen = 0;
         pages_opened   = 0;
         too_tall_seen  = 0;
         no_page_seen   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (open_placements.size() == 0) begin
               report_mismatch($sformatf("no request outstanding (status %0d, page %0d)",
                                         rsp_status, rsp_page_number));
            end else begin
               due = open_placements.pop_front();
               if (rsp_status !== due.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, due.status));
               if (rsp_page_number !== due.page_number)
                  report_mismatch($sformatf("page %0d, expected %0d",
                                            rsp_page_number, due.page_number));
               if (rsp_pos_x !== due.pos_x)
                  report_mismatch($sformatf("x %0d, expected %0d", rsp_pos_x, due.pos_x));
               if (rsp_pos_y !== due.pos_y)
                  report_mismatch($sformatf("y %0d, expected %0d", rsp_pos_y, due.pos_y));
               if (rsp_size_class !== due.size_class)
                  report_mismatch($sformatf("class %0d, expected %0d",
                                            rsp_size_class, due.size_class));
               if (rsp_opened_page !== due.opened_page)
                  report_mismatch($sformatf("new-page flag %0d, expected %0d",
                                            rsp_opened_page, due.opened_page));
            end
            responses_seen++;
         end
         if (req_valid && req_ready) begin
            due = place_glyph(req_glyph_width, req_glyph_height);
            open_placements.push_back(due);
            requests_seen++;
            if (due.opened_page)
               pages_opened++;
            if (due.status == STATUS_TOO_TALL)
               too_tall_seen++;
            if (due.status == STATUS_NO_PAGE)
               no_page_seen++;
         end
      end
      placements_due = open_placements.size();
   end

endmodule

// ===== test/tb_glyph_atlas_shelf_allocator.sv =====
`timescale 1ns / 1ps

// Testbench for the glyph atlas shelf allocator.
// The top makes the stimulus and gives the verdict; the checker beside the block watches
// both channels, keeps its own model of the shelves and pages, and compares every response
// field by field with the placement it worked out when the request was accepted.
module tb_glyph_atlas_shelf_allocator;

   import gas_pkg::*;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int DIRECTED     = 16;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic [DIM_W-1:0]     req_glyph_width  = '0;
   logic [DIM_W-1:0]     req_glyph_height = '0;
   logic                 rsp_ready        = 1'b0;
   logic                 req_ready;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [PAGE_NO_W-1:0] rsp_page_number;
   logic [DIM_W-1:0]     rsp_pos_x;
   logic [DIM_W-1:0]     rsp_pos_y;
   logic [CLASS_O_W-1:0] rsp_size_class;
   logic                 rsp_opened_page;

   int mismatches;
   int placements_due;
   int requests_seen;
   int responses_seen;
   int pages_opened;
   int too_tall_seen;
   int no_page_seen;

   // Knobs for the current phase. The stall rate and the long hold-off are read by the
   // receiver process at the rising edge, so they are written with nonblocking updates.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int burn_pct       = 0;
   bit hold_requested = 1'b0;
   bit hold_done      = 1'b0;
   int cycle_count    = 0;

   // Directed requests, in order. They walk the class boundaries (heights 15/16, 31/32,
   // 63/64, 127/128), open a page in every class, and include a zero-sized glyph. On the
   // 32-row class a full-width glyph leaves the cursor at 256, so the following zero-width
   // glyph lands at column 256, which reads back as 0 once cut to eight bits, and the next
   // one wraps the shelf. On the 64-row class a wide glyph wraps to a second shelf, and on
   // the 128-row class a wrap runs out of shelves at once, so a new page is opened. Heights
   // of 128 and above are too tall for any class.
   logic [DIM_W-1:0] directed_w [DIRECTED] = '{8'd0,   8'd255, 8'd0,   8'd255,
                                                8'd0,   8'd0,   8'd10,  8'd200,
                                                8'd100, 8'd255, 8'd255, 8'd128,
                                                8'd255, 8'd0,   8'd170, 8'd85};
   logic [DIM_W-1:0] directed_h [DIRECTED] = '{8'd0,   8'd15,  8'd15,  8'd16,
                                                8'd31,  8'd31,  8'd32,  8'd63,
                                                8'd63,  8'd64,  8'd127, 8'd128,
                                                8'd255, 8'd200, 8'd85,  8'd5};

   glyph_atlas_shelf_allocator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_glyph_width  (req_glyph_width),
      .req_glyph_height (req_glyph_height),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_page_number  (rsp_page_number),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_size_class   (rsp_size_class),
      .rsp_opened_page  (rsp_opened_page)
   );

   glyph_atlas_shelf_checker chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_glyph_width  (req_glyph_width),
      .req_glyph_height (req_glyph_height),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_page_number  (rsp_page_number),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_size_class   (rsp_size_class),
      .rsp_opened_page  (rsp_opened_page),
      .fail_count       (mismatches),
      .placements_due   (placements_due),
      .requests_seen    (requests_seen),
      .responses_seen   (responses_seen),
      .pages_opened     (pages_opened),
      .too_tall_seen    (too_tall_seen),
      .no_page_seen     (no_page_seen)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Offer one glyph request, after a random number of idle cycles. Called at a rising edge
   // and returns at the rising edge where the request was taken. Ready is looked at on the
   // falling edge before, where it is settled and holds the value the next edge will see.
   task automatic send_glyph(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_glyph_width  <= w;
      req_glyph_height <= h;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Random requests for one phase. Most glyphs are small and low so that pages last and
   // the shelves fill, wrap and spill onto new pages many times over. A share of tall, wide
   // glyphs, one shelf per page, is mixed in where the phase asks for it to use up the page
   // store, after which every class meets the out-of-pages case.
   task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                            input int burn);
      int               n;
      int               roll;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      send_idle_pct   = idle_pct;
      recv_stall_pct <= stall_pct;
      burn_pct        = burn;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < burn_pct) begin
            w = DIM_W'($urandom_range(255, 180));
            h = DIM_W'($urandom_range(127, 64));
         end else begin
            roll = $urandom_range(99);
            if (roll < 40)
               h = DIM_W'($urandom_range(15, 0));
            else if (roll < 65)
               h = DIM_W'($urandom_range(31, 16));
            else if (roll < 80)
               h = DIM_W'($urandom_range(63, 32));
            else if (roll < 90)
               h = DIM_W'($urandom_range(127, 64));
            else
               h = DIM_W'($urandom_range(255, 128));
            roll = $urandom_range(99);
            if (roll < 70)
               w = DIM_W'($urandom_range(31, 0));
            else if (roll < 90)
               w = DIM_W'($urandom_range(127, 32));
            else
               w = DIM_W'($urandom_range(255, 128));
         end
         send_glyph(w, h);
      end
   endtask

   // Receiver. Normally it stalls at the phase's rate; once asked, it holds ready low for a
   // long stretch, counted here, so that the block fills up and stops taking requests.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_requested && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Guard against a hang: the run should finish in a small fraction of this.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d responses still due",
               cycle_count, placements_due);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int i;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED; i++)
         send_glyph(directed_w[i], directed_h[i]);

      // Full rate on both sides first, then the long hold-off with the sender still pushing,
      // then a slow sender, then light idling on both sides while the pages run out.
      run_phase(350, 0, 0, 0);
      hold_requested <= 1'b1;
      run_phase(350, 0, 59, 0);
      run_phase(350, 59, 0, 0);
      run_phase(400, 8, 8, 30);
      req_valid <= 1'b0;

      wait (placements_due == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d glyph requests and %0d responses; %0d pages opened in all.",
               requests_seen, responses_seen, pages_opened);
      $display("Of these %0d were too tall and %0d found the page store exhausted.",
               too_tall_seen, no_page_seen);
      if (mismatches == 0 && placements_due == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
